>>> src/pls3_pkg.sv
// shared types and constants for the 3d polyline simplifier
// used by pls3_dist, pls3_datapath, pls3_ctrl and polyline_simplifier_3d
`timescale 1ns / 1ps

package pls3_pkg;

   // fixed field widths
   localparam int COORD_W    = 16;
   localparam int SRC_W      = 6;
   localparam int TOL_W      = 34;
   localparam int CSR_IDX_W  = 1;

   // arithmetic widths of the distance engine
   localparam int DIF_W      = COORD_W + 1;
   localparam int SQ_W       = 2 * DIF_W;
   localparam int NUM_W      = SQ_W + 2;
   localparam int PROD_W     = 2 * SQ_W;
   localparam int DCNT_W     = 7;

   // parameter defaults
   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SQ_TOL  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL  = 1'd1;

   // point store write data select
   localparam logic [1:0] WSEL_IN     = 2'd0;
   localparam logic [1:0] WSEL_RD     = 2'd1;
   localparam logic [1:0] WSEL_LATEST = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pt_type;

   typedef struct packed {
      logic             st_we;
      logic [1:0]       st_wsel;
      logic [SRC_W-1:0] st_waddr;
      logic             st_re;
      logic [SRC_W-1:0] st_raddr;
      logic             ld_latest;
      logic             ld_a;
      logic             ld_b;
      logic             best_init;
      logic             best_upd;
      logic             dist_start;
      logic             stk_we;
      logic [SRC_W-1:0] stk_waddr;
      logic [SRC_W-1:0] stk_wf;
      logic [SRC_W-1:0] stk_wl;
      logic             stk_re;
      logic [SRC_W-1:0] stk_raddr;
      logic             out_ld;
      logic [SRC_W-1:0] out_idx;
      logic             out_final;
      logic             out_ovf;
   } cmd_type;

   typedef struct packed {
      logic             radial_en;
      logic             dist_done;
      logic             dist_gt;
      logic             same_pt;
      logic [SRC_W-1:0] stk_f;
      logic [SRC_W-1:0] stk_l;
   } sts_type;

endpackage

>>> src/polyline_simplifier_3d.sv
// Points load at one item per cycle until the item with end_of_line.
// Then the radial pass (when enabled) and each segment scan run their points
// through a shared distance engine (17x17 multiplier, 34-step shift-add
// multiply twice, 68-step divider); kept items are then emitted in index
// order. Synchronous reset clears control, counters, keep marks
// and config registers; point store and segment stack are not cleared.
`timescale 1ns / 1ps

module polyline_simplifier_3d #(
   parameter int MAX_POINTS = pls3_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pls3_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [pls3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pls3_pkg::TOL_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [pls3_pkg::COORD_W-1:0] req_pt_x,
   input  logic signed [pls3_pkg::COORD_W-1:0] req_pt_y,
   input  logic signed [pls3_pkg::COORD_W-1:0] req_pt_z,
   input  logic                           req_end_of_line,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_z,
   output logic [pls3_pkg::SRC_W-1:0]     rsp_src_index,
   output logic                           rsp_final_flag,
   output logic                           rsp_overflow
);
   import pls3_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pls3_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_end_of_line (req_end_of_line),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .sts             (sts)
   );

   pls3_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_pt_x       (req_pt_x),
      .req_pt_y       (req_pt_y),
      .req_pt_z       (req_pt_z),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_src_index  (rsp_src_index),
      .rsp_final_flag (rsp_final_flag),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

>>> src/pls3_dist.sv
// squared distance of a point to a clamped segment, multicycle
// shared 17x17 multiplier, then shift-add multiplier and restoring divider
`timescale 1ns / 1ps

module pls3_dist (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pls3_pkg::pt_type      p,
   input  pls3_pkg::pt_type      a,
   input  pls3_pkg::pt_type      b,
   output logic                  done,
   output logic [pls3_pkg::SQ_W-1:0] sq_dist
);
   import pls3_pkg::*;

   localparam logic [2:0] D_IDLE = 3'd0;
   localparam logic [2:0] D_PROD = 3'd1;
   localparam logic [2:0] D_DEC  = 3'd2;
   localparam logic [2:0] D_MUL1 = 3'd3;
   localparam logic [2:0] D_MUL2 = 3'd4;
   localparam logic [2:0] D_DIV  = 3'd5;
   localparam logic [2:0] D_FIN  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic signed [DIF_W-1:0] v_ff [3], v_in [3];
   logic signed [DIF_W-1:0] d_ff [3], d_in [3];
   logic signed [DIF_W-1:0] w_ff [3], w_in [3];
   logic [1:0] lane_ff, lane_in, grp_ff, grp_in, pgrp_ff, pgrp_in;
   logic issue_ff, issue_in, pvld_ff, pvld_in;
   logic signed [SQ_W-1:0] prod_ff, prod_in;
   logic signed [DIF_W-1:0] op_a, op_b;
   logic [SQ_W-1:0] den_ff, den_in, vv_ff, vv_in, ww_ff, ww_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [SQ_W-1:0] mplier_ff, mplier_in, rem_ff, rem_in;
   logic [SQ_W:0] trial;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;
   logic [SQ_W-1:0] dist_ff, dist_in;

   // operand select of the shared small multiplier
   always_comb begin
      unique case (grp_ff)
         2'd0: begin
            op_a = d_ff[lane_ff];
            op_b = d_ff[lane_ff];
         end
         2'd1: begin
            op_a = v_ff[lane_ff];
            op_b = v_ff[lane_ff];
         end
         2'd2: begin
            op_a = v_ff[lane_ff];
            op_b = d_ff[lane_ff];
         end
         default: begin
            op_a = w_ff[lane_ff];
            op_b = w_ff[lane_ff];
         end
      endcase
   end

   assign trial = {rem_ff, acc_ff[PROD_W-1]};

   always_comb begin
      state_in  = state_ff;
      v_in      = v_ff;
      d_in      = d_ff;
      w_in      = w_ff;
      lane_in   = lane_ff;
      grp_in    = grp_ff;
      pgrp_in   = grp_ff;
      issue_in  = issue_ff;
      pvld_in   = 1'b0;
      prod_in   = op_a * op_b;
      den_in    = den_ff;
      vv_in     = vv_ff;
      ww_in     = ww_ff;
      num_in    = num_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      dist_in   = dist_ff;

      // accumulate the product issued in the previous cycle
      if (pvld_ff) begin
         unique case (pgrp_ff)
            2'd0:    den_in = den_ff + prod_ff[SQ_W-1:0];
            2'd1:    vv_in  = vv_ff + prod_ff[SQ_W-1:0];
            2'd2:    num_in = num_ff + NUM_W'(prod_ff);
            default: ww_in  = ww_ff + prod_ff[SQ_W-1:0];
         endcase
      end

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               v_in[0] = DIF_W'(p.x) - DIF_W'(a.x);
               v_in[1] = DIF_W'(p.y) - DIF_W'(a.y);
               v_in[2] = DIF_W'(p.z) - DIF_W'(a.z);
               d_in[0] = DIF_W'(b.x) - DIF_W'(a.x);
               d_in[1] = DIF_W'(b.y) - DIF_W'(a.y);
               d_in[2] = DIF_W'(b.z) - DIF_W'(a.z);
               w_in[0] = DIF_W'(p.x) - DIF_W'(b.x);
               w_in[1] = DIF_W'(p.y) - DIF_W'(b.y);
               w_in[2] = DIF_W'(p.z) - DIF_W'(b.z);
               den_in   = '0;
               vv_in    = '0;
               ww_in    = '0;
               num_in   = '0;
               lane_in  = 2'd0;
               grp_in   = 2'd0;
               issue_in = 1'b1;
               state_in = D_PROD;
            end
         end
         D_PROD: begin
            if (issue_ff) begin
               pvld_in = 1'b1;
               if (lane_ff == 2'd2) begin
                  lane_in = 2'd0;
                  grp_in  = grp_ff + 2'd1;
                  if (grp_ff == 2'd3) issue_in = 1'b0;
               end else begin
                  lane_in = lane_ff + 2'd1;
               end
            end else begin
               state_in = D_DEC;
            end
         end
         D_DEC: begin
            if (den_ff == '0 || num_ff <= 0) begin
               dist_in  = vv_ff;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if (num_ff[SQ_W:0] > {1'b0, den_ff}) begin
               dist_in  = ww_ff;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               acc_in    = '0;
               mcand_in  = PROD_W'(vv_ff);
               mplier_in = den_ff;
               cnt_in    = '0;
               state_in  = D_MUL1;
            end
         end
         D_MUL1, D_MUL2: begin
            if (mplier_ff[0]) begin
               if (state_ff == D_MUL1) acc_in = acc_ff + mcand_ff;
               else acc_in = acc_ff - mcand_ff;
            end
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SQ_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(SQ_W - 1)) begin
               cnt_in = '0;
               if (state_ff == D_MUL1) begin
                  // second pass subtracts num squared
                  mcand_in  = PROD_W'(num_ff[SQ_W-1:0]);
                  mplier_in = num_ff[SQ_W-1:0];
                  state_in  = D_MUL2;
               end else begin
                  rem_in   = '0;
                  state_in = D_DIV;
               end
            end
         end
         D_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = SQ_W'(trial - {1'b0, den_ff});
               acc_in = {acc_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[SQ_W-1:0];
               acc_in = {acc_ff[PROD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(PROD_W - 1)) state_in = D_FIN;
         end
         D_FIN: begin
            dist_in  = acc_ff[SQ_W-1:0];
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         issue_ff <= 1'b0;
         pvld_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pvld_ff  <= pvld_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      d_ff      <= d_in;
      w_ff      <= w_in;
      lane_ff   <= lane_in;
      grp_ff    <= grp_in;
      pgrp_ff   <= pgrp_in;
      prod_ff   <= prod_in;
      den_ff    <= den_in;
      vv_ff     <= vv_in;
      ww_ff     <= ww_in;
      num_ff    <= num_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      dist_ff   <= dist_in;
   end

   assign done    = done_ff;
   assign sq_dist = dist_ff;

endmodule

>>> src/pls3_datapath.sv
// datapath: point store, segment stack, config registers, distance engine
// and result registers; depends on pls3_pkg and pls3_dist
`timescale 1ns / 1ps

module pls3_datapath #(
   parameter int MAX_POINTS = pls3_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = pls3_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [pls3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pls3_pkg::TOL_W-1:0]     csr_wdata,
   input  logic [pls3_pkg::COORD_W-1:0]   req_pt_x,
   input  logic [pls3_pkg::COORD_W-1:0]   req_pt_y,
   input  logic [pls3_pkg::COORD_W-1:0]   req_pt_z,
   input  pls3_pkg::cmd_type              cmd,
   output pls3_pkg::sts_type              sts,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [pls3_pkg::COORD_W-1:0] rsp_out_z,
   output logic [pls3_pkg::SRC_W-1:0]     rsp_src_index,
   output logic                           rsp_final_flag,
   output logic                           rsp_overflow
);
   import pls3_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int PT_W  = 3 * COORD_BITS;

   function automatic pt_type to_pt(input logic [PT_W-1:0] raw);
      pt_type r;
      r.x = COORD_W'(signed'(raw[COORD_BITS-1:0]));
      r.y = COORD_W'(signed'(raw[2*COORD_BITS-1:COORD_BITS]));
      r.z = COORD_W'(signed'(raw[3*COORD_BITS-1:2*COORD_BITS]));
      return r;
   endfunction

   logic [PT_W-1:0] store_mem [MAX_POINTS];
   logic [2*IDX_W-1:0] stk_mem [MAX_POINTS];
   logic [PT_W-1:0] rd_ff, a_ff, b_ff, latest_ff, st_wdata;
   logic [2*IDX_W-1:0] stk_rd_ff;
   logic [TOL_W-1:0] tol_ff, best_ff;
   logic radial_ff;
   logic dist_done;
   logic [SQ_W-1:0] sq_dist;
   pt_type rd_pt;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= '0;
         radial_ff <= 1'b0;
      end else if (csr_write_en) begin
         if (csr_index == CSR_SQ_TOL) tol_ff <= csr_wdata;
         if (csr_index == CSR_RADIAL) radial_ff <= csr_wdata[0];
      end
   end

   always_comb begin
      unique case (cmd.st_wsel)
         WSEL_IN:     st_wdata = {req_pt_z[COORD_BITS-1:0], req_pt_y[COORD_BITS-1:0],
                                  req_pt_x[COORD_BITS-1:0]};
         WSEL_RD:     st_wdata = rd_ff;
         WSEL_LATEST: st_wdata = latest_ff;
         default:     st_wdata = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.st_we) store_mem[cmd.st_waddr[IDX_W-1:0]] <= st_wdata;
      if (cmd.st_re) rd_ff <= store_mem[cmd.st_raddr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.stk_we) begin
         stk_mem[cmd.stk_waddr[IDX_W-1:0]] <= {cmd.stk_wf[IDX_W-1:0],
                                               cmd.stk_wl[IDX_W-1:0]};
      end
      if (cmd.stk_re) stk_rd_ff <= stk_mem[cmd.stk_raddr[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_latest) latest_ff <= rd_ff;
      if (cmd.ld_a) a_ff <= rd_ff;
      if (cmd.ld_b) b_ff <= rd_ff;
      if (cmd.best_init) best_ff <= tol_ff;
      else if (cmd.best_upd) best_ff <= sq_dist;
   end

   assign rd_pt = to_pt(rd_ff);

   pls3_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.dist_start),
      .p       (rd_pt),
      .a       (to_pt(a_ff)),
      .b       (to_pt(b_ff)),
      .done    (dist_done),
      .sq_dist (sq_dist)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_out_x      <= rd_pt.x;
         rsp_out_y      <= rd_pt.y;
         rsp_out_z      <= rd_pt.z;
         rsp_src_index  <= cmd.out_idx;
         rsp_final_flag <= cmd.out_final;
         rsp_overflow   <= cmd.out_ovf;
      end
   end

   assign sts.radial_en = radial_ff;
   assign sts.dist_done = dist_done;
   assign sts.dist_gt   = sq_dist > best_ff;
   assign sts.same_pt   = (a_ff == latest_ff);
   assign sts.stk_f     = SRC_W'(stk_rd_ff[2*IDX_W-1:IDX_W]);
   assign sts.stk_l     = SRC_W'(stk_rd_ff[IDX_W-1:0]);

endmodule

>>> src/pls3_ctrl.sv
// controller: loads points, sequences the radial pass, the segment walk
// and the result emission; depends on pls3_pkg
`timescale 1ns / 1ps

module pls3_ctrl #(
   parameter int MAX_POINTS = pls3_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_end_of_line,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pls3_pkg::cmd_type cmd,
   input  pls3_pkg::sts_type sts
);
   import pls3_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);
   localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

   localparam logic [4:0] S_LOAD    = 5'd0;
   localparam logic [4:0] S_START   = 5'd1;
   localparam logic [4:0] S_R_LAT   = 5'd2;
   localparam logic [4:0] S_R_PRV   = 5'd3;
   localparam logic [4:0] S_R_RD    = 5'd4;
   localparam logic [4:0] S_R_GO    = 5'd5;
   localparam logic [4:0] S_R_WAIT  = 5'd6;
   localparam logic [4:0] S_R_END   = 5'd7;
   localparam logic [4:0] S_DP_INIT = 5'd8;
   localparam logic [4:0] S_POP     = 5'd9;
   localparam logic [4:0] S_SEG     = 5'd10;
   localparam logic [4:0] S_SEG_A   = 5'd11;
   localparam logic [4:0] S_SEG_B   = 5'd12;
   localparam logic [4:0] S_SCAN    = 5'd13;
   localparam logic [4:0] S_D_GO    = 5'd14;
   localparam logic [4:0] S_D_WAIT  = 5'd15;
   localparam logic [4:0] S_SEG_END = 5'd16;
   localparam logic [4:0] S_PUSH2   = 5'd17;
   localparam logic [4:0] S_SHORT   = 5'd18;
   localparam logic [4:0] S_E_RD    = 5'd19;
   localparam logic [4:0] S_E_LD    = 5'd20;
   localparam logic [4:0] S_E_HOLD  = 5'd21;
   localparam logic [4:0] S_FIN     = 5'd22;

   logic [4:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, n_ff, n_in, i_ff, i_in;
   logic [CNT_W-1:0] w_ff, w_in, sp_ff, sp_in, n_last;
   logic [IDX_W-1:0] f_ff, f_in, l_ff, l_in, idx_ff, idx_in;
   logic found_ff, found_in, ovf_ff, ovf_in, valid_ff, valid_in;
   logic [MAX_POINTS-1:0] keep_ff, keep_in;
   logic accept, room;

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;
   assign room      = (count_ff < MAX_CNT);
   assign n_last    = n_ff - ONE_CNT;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      w_in     = w_ff;
      sp_in    = sp_ff;
      f_in     = f_ff;
      l_in     = l_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      ovf_in   = ovf_ff;
      valid_in = valid_ff;
      keep_in  = keep_ff;
      cmd      = '0;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (room) begin
                  cmd.st_we    = 1'b1;
                  cmd.st_wsel  = WSEL_IN;
                  cmd.st_waddr = SRC_W'(count_ff);
                  count_in     = count_ff + ONE_CNT;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_line) begin
                  n_in     = room ? count_ff + ONE_CNT : count_ff;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (n_ff > TWO_CNT) begin
               if (sts.radial_en) begin
                  cmd.st_re    = 1'b1;
                  cmd.st_raddr = SRC_W'(n_last);
                  state_in     = S_R_LAT;
               end else begin
                  state_in = S_DP_INIT;
               end
            end else begin
               state_in = S_SHORT;
            end
         end
         // radial pre-filter, compacting in place
         S_R_LAT: begin
            cmd.ld_latest = 1'b1;
            cmd.st_re     = 1'b1;
            cmd.st_raddr  = '0;
            state_in      = S_R_PRV;
         end
         S_R_PRV: begin
            cmd.ld_a      = 1'b1;
            cmd.ld_b      = 1'b1;
            cmd.best_init = 1'b1;
            i_in          = ONE_CNT;
            w_in          = ONE_CNT;
            state_in      = S_R_RD;
         end
         S_R_RD: begin
            if (i_ff == n_ff) begin
               state_in = S_R_END;
            end else begin
               cmd.st_re    = 1'b1;
               cmd.st_raddr = SRC_W'(i_ff);
               state_in     = S_R_GO;
            end
         end
         S_R_GO: begin
            cmd.dist_start = 1'b1;
            state_in       = S_R_WAIT;
         end
         S_R_WAIT: begin
            if (sts.dist_done) begin
               if (sts.dist_gt) begin
                  cmd.st_we    = 1'b1;
                  cmd.st_wsel  = WSEL_RD;
                  cmd.st_waddr = SRC_W'(w_ff);
                  cmd.ld_a     = 1'b1;
                  cmd.ld_b     = 1'b1;
                  w_in         = w_ff + ONE_CNT;
               end
               i_in     = i_ff + ONE_CNT;
               state_in = S_R_RD;
            end
         end
         S_R_END: begin
            // re-append the final point when it was filtered away
            if (!sts.same_pt && w_ff < MAX_CNT) begin
               cmd.st_we    = 1'b1;
               cmd.st_wsel  = WSEL_LATEST;
               cmd.st_waddr = SRC_W'(w_ff);
               n_in         = w_ff + ONE_CNT;
            end else begin
               n_in = w_ff;
            end
            state_in = (n_in > TWO_CNT) ? S_DP_INIT : S_SHORT;
         end
         // segment walk
         S_DP_INIT: begin
            keep_in[0]                  = 1'b1;
            keep_in[n_last[IDX_W-1:0]]  = 1'b1;
            cmd.stk_we    = 1'b1;
            cmd.stk_waddr = '0;
            cmd.stk_wf    = '0;
            cmd.stk_wl    = SRC_W'(n_last);
            sp_in         = ONE_CNT;
            state_in      = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               i_in     = '0;
               state_in = S_E_RD;
            end else begin
               cmd.stk_re    = 1'b1;
               cmd.stk_raddr = SRC_W'(sp_ff - ONE_CNT);
               sp_in         = sp_ff - ONE_CNT;
               state_in      = S_SEG;
            end
         end
         S_SEG: begin
            f_in         = sts.stk_f[IDX_W-1:0];
            l_in         = sts.stk_l[IDX_W-1:0];
            cmd.st_re    = 1'b1;
            cmd.st_raddr = sts.stk_f;
            state_in     = S_SEG_A;
         end
         S_SEG_A: begin
            cmd.ld_a     = 1'b1;
            cmd.st_re    = 1'b1;
            cmd.st_raddr = SRC_W'(l_ff);
            state_in     = S_SEG_B;
         end
         S_SEG_B: begin
            cmd.ld_b      = 1'b1;
            cmd.best_init = 1'b1;
            found_in      = 1'b0;
            i_in          = CNT_W'(f_ff) + ONE_CNT;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (i_ff == CNT_W'(l_ff)) begin
               state_in = S_SEG_END;
            end else begin
               cmd.st_re    = 1'b1;
               cmd.st_raddr = SRC_W'(i_ff);
               state_in     = S_D_GO;
            end
         end
         S_D_GO: begin
            cmd.dist_start = 1'b1;
            state_in       = S_D_WAIT;
         end
         S_D_WAIT: begin
            if (sts.dist_done) begin
               if (sts.dist_gt) begin
                  cmd.best_upd = 1'b1;
                  idx_in       = i_ff[IDX_W-1:0];
                  found_in     = 1'b1;
               end
               i_in     = i_ff + ONE_CNT;
               state_in = S_SCAN;
            end
         end
         S_SEG_END: begin
            if (found_ff) begin
               keep_in[idx_ff] = 1'b1;
               if ((idx_ff - f_ff) > ONE_IDX && sp_ff < MAX_CNT) begin
                  cmd.stk_we    = 1'b1;
                  cmd.stk_waddr = SRC_W'(sp_ff);
                  cmd.stk_wf    = SRC_W'(f_ff);
                  cmd.stk_wl    = SRC_W'(idx_ff);
                  sp_in         = sp_ff + ONE_CNT;
               end
               state_in = S_PUSH2;
            end else begin
               state_in = S_POP;
            end
         end
         S_PUSH2: begin
            if ((l_ff - idx_ff) > ONE_IDX && sp_ff < MAX_CNT) begin
               cmd.stk_we    = 1'b1;
               cmd.stk_waddr = SRC_W'(sp_ff);
               cmd.stk_wf    = SRC_W'(idx_ff);
               cmd.stk_wl    = SRC_W'(l_ff);
               sp_in         = sp_ff + ONE_CNT;
            end
            state_in = S_POP;
         end
         S_SHORT: begin
            for (int j = 0; j < MAX_POINTS; j++) begin
               keep_in[j] = (CNT_W'(j) < n_ff);
            end
            i_in     = '0;
            state_in = S_E_RD;
         end
         // emission in index order
         S_E_RD: begin
            if (i_ff == n_ff) begin
               state_in = S_FIN;
            end else if (keep_ff[i_ff[IDX_W-1:0]]) begin
               cmd.st_re    = 1'b1;
               cmd.st_raddr = SRC_W'(i_ff);
               state_in     = S_E_LD;
            end else begin
               i_in = i_ff + ONE_CNT;
            end
         end
         S_E_LD: begin
            cmd.out_ld    = 1'b1;
            cmd.out_idx   = SRC_W'(i_ff);
            cmd.out_final = (i_ff == n_last);
            cmd.out_ovf   = ovf_ff;
            valid_in      = 1'b1;
            state_in      = S_E_HOLD;
         end
         S_E_HOLD: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               i_in     = i_ff + ONE_CNT;
               state_in = S_E_RD;
            end
         end
         S_FIN: begin
            count_in = '0;
            ovf_in   = 1'b0;
            keep_in  = '0;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         n_ff     <= '0;
         i_ff     <= '0;
         w_ff     <= '0;
         sp_ff    <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
         keep_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         w_ff     <= w_in;
         sp_ff    <= sp_in;
         found_ff <= found_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
         keep_ff  <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff   <= f_in;
      l_ff   <= l_in;
      idx_ff <= idx_in;
   end

endmodule
